FILE: rtl/core/projected_point_box_select_top_assert.svh
// Assertion macros shared by the block's RTL.
`ifndef PROJECTED_POINT_BOX_SELECT_TOP_ASSERT_SVH
`define PROJECTED_POINT_BOX_SELECT_TOP_ASSERT_SVH

// Check an implication on every clock edge outside reset.
`define PPBS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppbs assertion failed");

// Check an implication in the next cycle.
`define PPBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppbs assertion failed");

`endif

FILE: rtl/core/ppbs_pkg.sv
// ----------------------------------------------------------------------------
// ppbs_pkg
// Shared types and constants of the projected point box select block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppbs_pkg;

    localparam int DIV_STEPS = 14;
    localparam int Q_W       = DIV_STEPS + 1;
    localparam int N_W       = 17;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;

    localparam logic signed [N_W-1:0] SAT_POS = 17'sd32767;
    localparam logic signed [N_W-1:0] SAT_NEG = -17'sd32768;
    localparam logic signed [N_W-1:0] HALF    = 17'sd16384;

    typedef enum logic [2:0] {
        REG_ROW_X    = 3'd0,
        REG_ROW_Y    = 3'd1,
        REG_ROW_W    = 3'd2,
        REG_X_BOUNDS = 3'd3,
        REG_Y_BOUNDS = 3'd4,
        REG_DESELECT = 3'd5
    } reg_idx_t;

    // Per-point side information that rides along with the division.
    typedef struct packed {
        logic cur;
        logic wzero;
        logic negx;
        logic negy;
        logic satx;
        logic saty;
    } side_t;

endpackage

FILE: rtl/core/ppbs_proj.sv
// ----------------------------------------------------------------------------
// ppbs_proj
// Matrix rows times point, row sums, magnitudes and first quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppbs_proj
    import ppbs_pkg::*;
#(
    parameter int CB = 32,
    parameter int CF = 16,
    parameter int SW = 50
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [DATA_W-1:0]    row_x,
    input  logic [DATA_W-1:0]    row_y,
    input  logic [DATA_W-1:0]    row_w,
    input  logic signed [CB-1:0] px,
    input  logic signed [CB-1:0] py,
    input  logic signed [CB-1:0] pz,
    input  logic                 cur,
    output logic [SW-1:0]        rx,
    output logic [SW-1:0]        ry,
    output logic [SW-1:0]        b,
    output logic [Q_W-1:0]       qx,
    output logic [Q_W-1:0]       qy,
    output side_t                side
);

    localparam int PW = CB + CF;
    localparam int G  = (PW > 62) ? PW - 62 : 0;

    logic signed [CF-1:0] coef [3][4];
    logic signed [PW-1:0] prod_reg [3][3];
    logic                 cur1_reg, cur2_reg;
    logic signed [SW-1:0] sum_reg [3];
    logic signed [SW-1:0] sum_next [3];
    logic [SW-1:0]        ax_reg, ay_reg, ab_reg;
    side_t                side3_reg;
    logic [SW:0]          twob;
    logic                 gex, gey;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            coef[0][k] = row_x[k*CF +: CF];
            coef[1][k] = row_y[k*CF +: CF];
            coef[2][k] = row_w[k*CF +: CF];
        end
    end

    // Stage 1: nine products, operands widened so each product is exact.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                prod_reg[r][0] <= PW'(coef[r][0]) * PW'(px);
                prod_reg[r][1] <= PW'(coef[r][1]) * PW'(py);
                prod_reg[r][2] <= PW'(coef[r][2]) * PW'(pz);
            end
            cur1_reg <= cur;
        end
    end

    // Stage 2: guard shift and sum with the constant term.
    always_comb
    begin
        logic signed [CF+15:0] cterm;
        for (int r = 0; r < 3; r++)
        begin
            cterm = {coef[r][3], 16'b0};
            sum_next[r] = SW'(prod_reg[r][0] >>> G) + SW'(prod_reg[r][1] >>> G)
                        + SW'(prod_reg[r][2] >>> G) + SW'(cterm >>> G);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                sum_reg[r] <= sum_next[r];
            cur2_reg <= cur1_reg;
        end
    end

    // Stage 3: signs and magnitudes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= sum_reg[0][SW-1] ? SW'(-sum_reg[0]) : SW'(sum_reg[0]);
            ay_reg <= sum_reg[1][SW-1] ? SW'(-sum_reg[1]) : SW'(sum_reg[1]);
            ab_reg <= sum_reg[2][SW-1] ? SW'(-sum_reg[2]) : SW'(sum_reg[2]);
            side3_reg.cur   <= cur2_reg;
            side3_reg.wzero <= (sum_reg[2] == '0);
            side3_reg.negx  <= sum_reg[0][SW-1] ^ sum_reg[2][SW-1];
            side3_reg.negy  <= sum_reg[1][SW-1] ^ sum_reg[2][SW-1];
            side3_reg.satx  <= 1'b0;
            side3_reg.saty  <= 1'b0;
        end
    end

    // Stage 4: overflow test and integer quotient bit.
    assign twob = {ab_reg, 1'b0};
    assign gex  = (ax_reg >= ab_reg);
    assign gey  = (ay_reg >= ab_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx   <= gex ? ax_reg - ab_reg : ax_reg;
            ry   <= gey ? ay_reg - ab_reg : ay_reg;
            qx   <= {{(Q_W-1){1'b0}}, gex};
            qy   <= {{(Q_W-1){1'b0}}, gey};
            b    <= ab_reg;
            side <= '{cur:   side3_reg.cur,
                       wzero: side3_reg.wzero,
                       negx:  side3_reg.negx,
                       negy:  side3_reg.negy,
                       satx:  ({1'b0, ax_reg} >= twob),
                       saty:  ({1'b0, ay_reg} >= twob)};
        end
    end

endmodule

FILE: rtl/core/ppbs_div_cell.sv
// ----------------------------------------------------------------------------
// ppbs_div_cell
// One restoring division step for the x and y lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppbs_div_cell
    import ppbs_pkg::*;
#(
    parameter int SW = 50
)
(
    input  logic           clk,
    input  logic           en,
    input  logic [SW-1:0]  rx_in,
    input  logic [SW-1:0]  ry_in,
    input  logic [SW-1:0]  b_in,
    input  logic [Q_W-1:0] qx_in,
    input  logic [Q_W-1:0] qy_in,
    input  side_t          side_in,
    output logic [SW-1:0]  rx_out,
    output logic [SW-1:0]  ry_out,
    output logic [SW-1:0]  b_out,
    output logic [Q_W-1:0] qx_out,
    output logic [Q_W-1:0] qy_out,
    output side_t          side_out
);

    logic [SW:0] tx, ty, bb;
    logic        gx, gy;

    assign tx = {rx_in, 1'b0};
    assign ty = {ry_in, 1'b0};
    assign bb = {1'b0, b_in};
    assign gx = (tx >= bb);
    assign gy = (ty >= bb);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_out   <= SW'(gx ? tx - bb : tx);
            ry_out   <= SW'(gy ? ty - bb : ty);
            b_out    <= b_in;
            qx_out   <= {qx_in[Q_W-2:0], gx};
            qy_out   <= {qy_in[Q_W-2:0], gy};
            side_out <= side_in;
        end
    end

endmodule

FILE: rtl/core/ppbs_cull.sv
// ----------------------------------------------------------------------------
// ppbs_cull
// Sign, saturate, map to 0..1 and test against the rectangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppbs_cull
    import ppbs_pkg::*;
(
    input  logic           clk,
    input  logic           en,
    input  logic [Q_W-1:0] qx,
    input  logic [Q_W-1:0] qy,
    input  side_t          side,
    input  logic [31:0]    x_bounds,
    input  logic [31:0]    y_bounds,
    input  logic           deselect,
    output logic           new_select,
    output logic           inside_box,
    output logic           w_was_zero
);

    function automatic logic signed [N_W-1:0] map_q(logic [Q_W-1:0] q, logic neg, logic sat);
        logic signed [N_W-1:0] s;
        logic signed [N_W-1:0] m;
        if (sat)
            s = neg ? SAT_NEG : SAT_POS;
        else
            s = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
        m = s + HALF;
        return m >>> 1;
    endfunction

    function automatic logic in_rng(logic signed [N_W-1:0] v, logic [31:0] bnd);
        logic signed [N_W-1:0] a;
        logic signed [N_W-1:0] c;
        a = N_W'($signed(bnd[15:0]));
        c = N_W'($signed(bnd[31:16]));
        if (a > c)
            return (v >= c) && (v <= a);
        return (v >= a) && (v <= c);
    endfunction

    logic in_now;

    assign in_now = !side.wzero
                  && in_rng(map_q(qx, side.negx, side.satx), x_bounds)
                  && in_rng(map_q(qy, side.negy, side.saty), y_bounds);

    // Hold the result beat until it is taken.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_box <= in_now;
            w_was_zero <= side.wzero;
            new_select <= in_now ? !deselect : side.cur;
        end
    end

endmodule

FILE: rtl/core/projected_point_box_select_top.sv
// ----------------------------------------------------------------------------
// projected_point_box_select_top
// Streaming rectangle selection of perspective-projected points.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one Q16.16 point plus its selection bit on in_valid /
//   in_stall; result beats carry new_select, inside_box and w_was_zero on
//   out_valid / out_stall. One result beat leaves for every input beat, in
//   order.
//   Throughput is one point per cycle unless the receiver stalls; the pipeline
//   holds 19 beats: four projection stages (products, row sums, magnitudes,
//   overflow test), a row of fourteen division cells producing one quotient
//   bit each, and the rectangle test feeding the output register. When the
//   receiver stalls with a result waiting, the whole pipeline holds and
//   in_stall rises in the same cycle; with the output register empty the
//   pipeline keeps advancing. Reset clears all beat valids and configuration
//   registers; no clearing pass is needed. The user must write configuration
//   over the APB port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "projected_point_box_select_top_assert.svh"

module projected_point_box_select_top
    import ppbs_pkg::*;
#(
    parameter int COORD_BITS = 32,
    parameter int COEFF_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic                         current_select,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         new_select,
    output logic                         inside_box,
    output logic                         w_was_zero,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_W-1:0]            paddr,
    input  logic [DATA_W-1:0]            pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    localparam int PW  = COORD_BITS + COEFF_BITS;
    localparam int G   = (PW > 62) ? PW - 62 : 0;
    localparam int TW  = ((PW > COEFF_BITS + 17) ? PW : COEFF_BITS + 17) - G;
    localparam int SW  = TW + 2;
    localparam int NST = 4 + DIV_STEPS + 1;

    // Configuration registers.
    logic [DATA_W-1:0] row_x_reg, row_y_reg, row_w_reg;
    logic [31:0]       x_bounds_reg, y_bounds_reg;
    logic              deselect_reg;
    logic              wr_en;
    reg_idx_t          idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg    <= '0;
            row_y_reg    <= '0;
            row_w_reg    <= '0;
            x_bounds_reg <= '0;
            y_bounds_reg <= '0;
            deselect_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_ROW_X:    row_x_reg    <= pwdata;
                REG_ROW_Y:    row_y_reg    <= pwdata;
                REG_ROW_W:    row_w_reg    <= pwdata;
                REG_X_BOUNDS: x_bounds_reg <= pwdata[31:0];
                REG_Y_BOUNDS: y_bounds_reg <= pwdata[31:0];
                REG_DESELECT: deselect_reg <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_ROW_X:    prdata = row_x_reg;
            REG_ROW_Y:    prdata = row_y_reg;
            REG_ROW_W:    prdata = row_w_reg;
            REG_X_BOUNDS: prdata = {32'b0, x_bounds_reg};
            REG_Y_BOUNDS: prdata = {32'b0, y_bounds_reg};
            REG_DESELECT: prdata = {{(DATA_W-1){1'b0}}, deselect_reg};
            default:      prdata = '0;
        endcase
    end

    // Advance the pipeline unless a waiting result beat is stalled.
    logic           adv;
    logic [NST-1:0] vld_reg;

    assign adv       = !(vld_reg[NST-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], in_valid};
    end

    // Projection front end.
    logic [SW-1:0]  rx [DIV_STEPS+1];
    logic [SW-1:0]  ry [DIV_STEPS+1];
    logic [SW-1:0]  bw [DIV_STEPS+1];
    logic [Q_W-1:0] qx [DIV_STEPS+1];
    logic [Q_W-1:0] qy [DIV_STEPS+1];
    side_t          sd [DIV_STEPS+1];

    ppbs_proj #(
        .CB(COORD_BITS),
        .CF(COEFF_BITS),
        .SW(SW)
    ) u_proj (
        .clk   (clk),
        .en    (adv),
        .row_x (row_x_reg),
        .row_y (row_y_reg),
        .row_w (row_w_reg),
        .px    (point_x),
        .py    (point_y),
        .pz    (point_z),
        .cur   (current_select),
        .rx    (rx[0]),
        .ry    (ry[0]),
        .b     (bw[0]),
        .qx    (qx[0]),
        .qy    (qy[0]),
        .side  (sd[0])
    );

    // Row of division cells, one fractional quotient bit per cell.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        ppbs_div_cell #(
            .SW(SW)
        ) u_cell (
            .clk      (clk),
            .en       (adv),
            .rx_in    (rx[i]),
            .ry_in    (ry[i]),
            .b_in     (bw[i]),
            .qx_in    (qx[i]),
            .qy_in    (qy[i]),
            .side_in  (sd[i]),
            .rx_out   (rx[i+1]),
            .ry_out   (ry[i+1]),
            .b_out    (bw[i+1]),
            .qx_out   (qx[i+1]),
            .qy_out   (qy[i+1]),
            .side_out (sd[i+1])
        );
    end

    // Rectangle test into the output register.
    ppbs_cull u_cull (
        .clk        (clk),
        .en         (adv),
        .qx         (qx[DIV_STEPS]),
        .qy         (qy[DIV_STEPS]),
        .side       (sd[DIV_STEPS]),
        .x_bounds   (x_bounds_reg),
        .y_bounds   (y_bounds_reg),
        .deselect   (deselect_reg),
        .new_select (new_select),
        .inside_box (inside_box),
        .w_was_zero (w_was_zero)
    );

    // A zero w never reports inside.
    `PPBS_ASSERT_IMPL(a_wzero_outside, out_valid, !(inside_box && w_was_zero))
    // An accepted beat enters the first stage.
    `PPBS_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_reg[0])
    // Inside points in select mode come out selected.
    `PPBS_ASSERT_IMPL(a_select_sets, out_valid && inside_box && !deselect_reg, new_select)

endmodule
